### hdl/pnr_pkg.sv
// shared types, constants and sample conversion for the pcm nearest resampler
package pnr_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int STEP_W    = 21;
   localparam int CSR_IDX_W = 2;
   localparam int MAX_RUN   = 64;
   localparam int RUN_CNT_W = $clog2(MAX_RUN);

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATIO   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO       = 2'd2;

   // sample width modes
   localparam logic WIDTH_MODE_8  = 1'b0;
   localparam logic WIDTH_MODE_16 = 1'b1;

   // register reset values
   localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

   // controller to datapath
   typedef struct packed {
      logic load;     // take a new source word and start a run
      logic skip;     // consume a source word with no output
      logic advance;  // one output word taken, step the position
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emits;    // the offered source word yields at least one output
      logic last;     // the current output word closes the run
   } dp_status_type;

   // eight-bit samples: flip the top bit to re-center, then move to the high byte
   function automatic logic [SAMPLE_W-1:0] convert_sample(input logic [SAMPLE_W-1:0] raw,
                                                          input logic mode);
      logic [SAMPLE_W-1:0] res;
      if (mode == WIDTH_MODE_8) begin
         res = {~raw[7], raw[6:0], 8'h00};
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

### hdl/pnr_ifs.sv
// valid/ready channel interfaces for the request, response and csr ports

interface pnr_req_if;
   logic                            valid;
   logic                            ready;
   logic [pnr_pkg::SAMPLE_W-1:0]    left_raw;
   logic [pnr_pkg::SAMPLE_W-1:0]    right_raw;
   logic                            stream_start;
   modport source (output valid, output left_raw, output right_raw, output stream_start,
                   input ready);
   modport sink (input valid, input left_raw, input right_raw, input stream_start,
                 output ready);
endinterface

interface pnr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pnr_pkg::SAMPLE_W-1:0]   left_sample;
   logic signed [pnr_pkg::SAMPLE_W-1:0]   right_sample;
   logic                                  run_last;
   modport source (output valid, output left_sample, output right_sample, output run_last,
                   input ready);
   modport sink (input valid, input left_sample, input right_sample, input run_last,
                 output ready);
endinterface

interface pnr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pnr_pkg::CSR_IDX_W-1:0]   reg_index;
   logic [pnr_pkg::STEP_W-1:0]      wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### hdl/pcm_nearest_resampler.sv
// pcm nearest resampler top level: channels, controller and datapath
//
//  channel   dir   handshake      word
//  req_chan  in    valid/ready    left_raw, right_raw, stream_start
//  rsp_chan  out   valid/ready    left_sample, right_sample, run_last
//  csr_chan  in    valid/ready    reg_index, wdata (always ready)
//
// A source word can be taken in the cycle after the previous run ends; the run
// then emits one output word per cycle while rsp ready is high, and a skipped
// word is consumed with no output.
// The run length is set by the position accumulator, capped at 64 words.
// Synchronous active-high reset clears the position and restores the registers.
// Output stalls hold the current word and position; no input is taken meanwhile.
module pcm_nearest_resampler #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   pnr_req_if.sink       req_chan,
   pnr_rsp_if.source     rsp_chan,
   pnr_csr_if.sink       csr_chan
);

   pnr_pkg::dp_cmd_type     cmd;
   pnr_pkg::dp_status_type  status;

   // csr writes are always accepted and take effect from the next cycle
   assign csr_chan.ready = 1'b1;

   pnr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pnr_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .left_raw     (req_chan.left_raw),
      .right_raw    (req_chan.right_raw),
      .stream_start (req_chan.stream_start),
      .csr_write    (csr_chan.valid && csr_chan.ready),
      .csr_index    (csr_chan.reg_index),
      .csr_data     (csr_chan.wdata),
      .left_sample  (rsp_chan.left_sample),
      .right_sample (rsp_chan.right_sample),
      .run_last     (rsp_chan.run_last)
   );

`ifndef SYNTH
   // input side never open while a run is being delivered
   assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready during output run");

   // the word marked last closes the run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.run_last) |=> !rsp_chan.valid)
      else $error("output continues after last word");

   // a stream start always yields at least one output word
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.stream_start) |=> rsp_chan.valid)
      else $error("stream start produced no output");
`endif

endmodule

### hdl/pnr_ctrl.sv
// run controller: takes source words and paces the output run
module pnr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pnr_pkg::dp_status_type  status,
   output pnr_pkg::dp_cmd_type     cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               if (status.emits) begin
                  cmd.load = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  cmd.skip = 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (rsp_ready && rsp_valid_ff) begin
               cmd.advance = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RUN);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/pnr_datapath.sv
// datapath: config registers, sample conversion, position accumulator, run counter
module pnr_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pnr_pkg::dp_cmd_type                   cmd,
   output pnr_pkg::dp_status_type                status,
   input  logic [pnr_pkg::SAMPLE_W-1:0]          left_raw,
   input  logic [pnr_pkg::SAMPLE_W-1:0]          right_raw,
   input  logic                                  stream_start,
   input  logic                                  csr_write,
   input  logic [pnr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pnr_pkg::STEP_W-1:0]            csr_data,
   output logic signed [pnr_pkg::SAMPLE_W-1:0]   left_sample,
   output logic signed [pnr_pkg::SAMPLE_W-1:0]   right_sample,
   output logic                                  run_last
);

   // position stays below one frame plus one step, so one bit over the wider of the two
   localparam int ACC_W = ((FRAC_BITS > pnr_pkg::STEP_W) ? FRAC_BITS : pnr_pkg::STEP_W) + 1;
   localparam logic [ACC_W-1:0] ONE_FRAME = ACC_W'(1) << FRAC_BITS;
   localparam logic [pnr_pkg::RUN_CNT_W-1:0] LAST_CNT =
      pnr_pkg::RUN_CNT_W'(pnr_pkg::MAX_RUN - 1);

   logic [pnr_pkg::STEP_W-1:0]     step_ff;
   logic                           width_mode_ff;
   logic                           stereo_ff;
   logic [ACC_W-1:0]               acc_ff;
   logic [pnr_pkg::RUN_CNT_W-1:0]  count_ff;
   logic [pnr_pkg::SAMPLE_W-1:0]   left_ff;
   logic [pnr_pkg::SAMPLE_W-1:0]   right_ff;

   logic [ACC_W-1:0]               sum;
   logic                           sum_ge_one;
   logic                           acc_ge_one;
   logic                           last;
   logic [pnr_pkg::SAMPLE_W-1:0]   left_conv;
   logic [pnr_pkg::SAMPLE_W-1:0]   right_conv;

   // position compares
   assign sum        = acc_ff + ACC_W'(step_ff);
   assign sum_ge_one = |sum[ACC_W-1:FRAC_BITS];
   assign acc_ge_one = |acc_ff[ACC_W-1:FRAC_BITS];
   assign last       = sum_ge_one || (count_ff == LAST_CNT);

   assign status.emits = stream_start || !acc_ge_one;
   assign status.last  = last;

   // source word conversion
   assign left_conv  = pnr_pkg::convert_sample(left_raw, width_mode_ff);
   assign right_conv = stereo_ff ? pnr_pkg::convert_sample(right_raw, width_mode_ff)
                                 : left_conv;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= pnr_pkg::STEP_RESET;
         width_mode_ff <= pnr_pkg::WIDTH_MODE_16;
         stereo_ff     <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            pnr_pkg::CSR_STEP_RATIO:   step_ff       <= csr_data;
            pnr_pkg::CSR_SAMPLE_WIDTH: width_mode_ff <= csr_data[0];
            pnr_pkg::CSR_STEREO:       stereo_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // position accumulator and run counter
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.load) begin
         if (stream_start) begin
            acc_ff <= '0;
         end
         count_ff <= '0;
      end else if (cmd.skip) begin
         acc_ff <= acc_ff - ONE_FRAME;
      end else if (cmd.advance) begin
         count_ff <= count_ff + 1'b1;
         if (!last) begin
            acc_ff <= sum;
         end else if (sum_ge_one) begin
            acc_ff <= sum - ONE_FRAME;
         end else begin
            // run capped inside the frame: restart at the next frame
            acc_ff <= '0;
         end
      end
   end

   // held output word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff  <= left_conv;
         right_ff <= right_conv;
      end
   end

   assign left_sample  = left_ff;
   assign right_sample = right_ff;
   assign run_last     = last;

endmodule

### tb/pcm_nearest_resampler_checker.sv
// checker for the pcm nearest resampler: predicts output words and compares them
module pcm_nearest_resampler_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   pnr_req_if   req_chan,
   pnr_rsp_if   rsp_chan,
   pnr_csr_if   csr_chan,
   output int   mismatch_count,
   output int   frames_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W = 24;
   localparam logic [POS_W-1:0] ONE_FRAME = POS_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [pnr_pkg::SAMPLE_W-1:0] left_sample;
      logic [pnr_pkg::SAMPLE_W-1:0] right_sample;
      logic                         run_last;
   } stereo_frame_type;

   // predicted output words, oldest first
   stereo_frame_type    expected_frames[$];

   // shadow copies of the registers and the position
   logic [pnr_pkg::STEP_W-1:0]   step_ratio;
   logic                         width_mode;
   logic                         stereo_src;
   logic [POS_W-1:0]             position;

   // eight-bit samples are re-centered and moved to the high byte
   function automatic logic [pnr_pkg::SAMPLE_W-1:0] to_pcm16(
      input logic [pnr_pkg::SAMPLE_W-1:0] raw);
      if (width_mode == pnr_pkg::WIDTH_MODE_8) begin
         return {raw[7:0] ^ 8'h80, 8'h00};
      end
      return raw;
   endfunction

   // one source word: repeat it while the output position lies on it
   task automatic expand_frame(input logic [pnr_pkg::SAMPLE_W-1:0] left_raw,
                               input logic [pnr_pkg::SAMPLE_W-1:0] right_raw,
                               input logic                         start);
      stereo_frame_type word;
      int               run_len;
      run_len = 0;
      if (start) begin
         position = '0;
      end
      word.left_sample  = to_pcm16(left_raw);
      word.right_sample = stereo_src ? to_pcm16(right_raw) : word.left_sample;
      word.run_last     = 1'b0;
      while (position < ONE_FRAME && run_len < pnr_pkg::MAX_RUN) begin
         expected_frames.push_back(word);
         run_len++;
         position = position + POS_W'(step_ratio);
      end
      if (run_len > 0) begin
         expected_frames[expected_frames.size()-1].run_last = 1'b1;
      end
      // a capped run drops what is left of this frame
      if (position >= ONE_FRAME) begin
         position = position - ONE_FRAME;
      end else begin
         position = '0;
      end
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      stereo_frame_type want;
      if (reset) begin
         step_ratio     = pnr_pkg::STEP_RESET;
         width_mode     = pnr_pkg::WIDTH_MODE_16;
         stereo_src     = 1'b1;
         position       = '0;
         mismatch_count = 0;
         expected_frames.delete();
      end else begin
         // output side first: a word never leaves on the edge its source arrives
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_frames.size() == 0) begin
               $error("unexpected output word: left %0d right %0d run_last %0b",
                      rsp_chan.left_sample, rsp_chan.right_sample, rsp_chan.run_last);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               compare_field("left_sample", $signed(want.left_sample),
                             $signed(rsp_chan.left_sample));
               compare_field("right_sample", $signed(want.right_sample),
                             $signed(rsp_chan.right_sample));
               compare_field("run_last", want.run_last, rsp_chan.run_last);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            expand_frame(req_chan.left_raw, req_chan.right_raw, req_chan.stream_start);
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.reg_index)
               pnr_pkg::CSR_STEP_RATIO: begin
                  step_ratio = csr_chan.wdata;
               end
               pnr_pkg::CSR_SAMPLE_WIDTH: begin
                  width_mode = csr_chan.wdata[0];
               end
               pnr_pkg::CSR_STEREO: begin
                  stereo_src = csr_chan.wdata[0];
               end
               default: begin
               end
            endcase
         end
      end
      frames_due = expected_frames.size();
   end

endmodule

### tb/pcm_nearest_resampler_test.sv
// testbench top for the pcm nearest resampler: clock, reset, stimulus and verdict
module pcm_nearest_resampler_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   localparam logic [pnr_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int BUSY_PCT        = 73;
   localparam int SHARED_PCT      = 22;
   localparam int PHASES          = 8;
   localparam int FRAMES_PER_PHASE = 55;
   localparam logic [pnr_pkg::STEP_W-1:0] STEP_ONE = 21'd65536;

   logic          clock;
   logic          reset;
   idle_mode_type idle_mode;
   bit            hold_request;
   int            mismatch_count;
   int            frames_due;

   pnr_req_if req_chan ();
   pnr_rsp_if rsp_chan ();
   pnr_csr_if csr_chan ();

   pcm_nearest_resampler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pcm_nearest_resampler_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .mismatch_count (mismatch_count),
      .frames_due     (frames_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // limit on the whole run
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // chance in a hundred that a side idles this cycle
   function automatic int idle_pct(input bit sender_side);
      case (idle_mode)
         IDLE_SEND: return sender_side ? BUSY_PCT : 0;
         IDLE_RECV: return sender_side ? 0 : BUSY_PCT;
         IDLE_BOTH: return SHARED_PCT;
         default:   return 0;
      endcase
   endfunction

   // output side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      bit hold_served;
      hold_left   = 0;
      hold_served = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= idle_pct(1'b0));
         end
      end
   end

   // offer one source word and wait for it to be taken
   task automatic push_frame(input logic [pnr_pkg::SAMPLE_W-1:0] left_raw,
                             input logic [pnr_pkg::SAMPLE_W-1:0] right_raw,
                             input logic                         start);
      while ($urandom_range(99) < idle_pct(1'b1)) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.left_raw     = left_raw;
      req_chan.right_raw    = right_raw;
      req_chan.stream_start = start;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [pnr_pkg::CSR_IDX_W-1:0] index,
                            input logic [pnr_pkg::STEP_W-1:0] value);
      csr_chan.valid     = 1'b1;
      csr_chan.reg_index = index;
      csr_chan.wdata     = value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [pnr_pkg::STEP_W-1:0] step, input logic width,
                             input logic stereo);
      write_reg(pnr_pkg::CSR_STEP_RATIO, step);
      write_reg(pnr_pkg::CSR_SAMPLE_WIDTH, pnr_pkg::STEP_W'(width));
      write_reg(pnr_pkg::CSR_STEREO, pnr_pkg::STEP_W'(stereo));
      csr_chan.valid = 1'b0;
   endtask

   // wait for every predicted word, then let a skipped word finish
   task automatic settle_block();
      req_chan.valid = 1'b0;
      while (frames_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random sample bits with the extremes mixed in
   function automatic logic [pnr_pkg::SAMPLE_W-1:0] pick_sample();
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0080;
            default: return 16'h007F;
         endcase
      end
      return pnr_pkg::SAMPLE_W'($urandom);
   endfunction

   initial begin
      logic [pnr_pkg::STEP_W-1:0] step;
      req_chan.valid        = 1'b0;
      req_chan.left_raw     = '0;
      req_chan.right_raw    = '0;
      req_chan.stream_start = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.reg_index    = pnr_pkg::CSR_STEP_RATIO;
      csr_chan.wdata        = '0;
      idle_mode             = IDLE_NONE;
      hold_request          = 1'b0;
      reset                 = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: unity step, sixteen-bit stereo, extreme samples
      push_frame(16'h0000, 16'hFFFF, 1'b1);
      push_frame(16'hFFFF, 16'h0000, 1'b0);
      push_frame(16'h8000, 16'h7FFF, 1'b0);
      push_frame(16'h7FFF, 16'h8000, 1'b0);
      settle_block();

      // unused register index, then eight-bit mono with skipped frames
      write_reg(CSR_SPARE, pnr_pkg::STEP_W'($urandom));
      set_config(21'h30000, pnr_pkg::WIDTH_MODE_8, 1'b0);
      push_frame(16'hAB00, 16'h1234, 1'b1);
      push_frame(16'h0080, 16'hFFFF, 1'b0);
      push_frame(16'hFF7F, 16'h0001, 1'b0);
      push_frame(16'h00FF, 16'h0000, 1'b0);
      push_frame(16'hFF00, 16'hFFFF, 1'b0);
      push_frame(16'h1234, 16'h5678, 1'b0);
      settle_block();

      // zero step: every frame hits the run cap
      set_config('0, pnr_pkg::WIDTH_MODE_16, 1'b1);
      push_frame(16'h1357, 16'h2468, 1'b1);
      push_frame(16'hFFFF, 16'h8000, 1'b0);
      settle_block();

      // tiny step: capped run drops the rest of the frame
      set_config(21'd1000, pnr_pkg::WIDTH_MODE_8, 1'b1);
      push_frame(16'h0000, 16'h00FF, 1'b0);
      push_frame(16'hFF80, 16'h7F7F, 1'b0);
      settle_block();

      // large steps skip many frames, then a small step gives long runs
      set_config(21'd1048576, pnr_pkg::WIDTH_MODE_16, 1'b0);
      push_frame(16'h8001, 16'h1111, 1'b1);
      push_frame(16'h7FFE, 16'h2222, 1'b0);
      push_frame(16'h4000, 16'h3333, 1'b0);
      settle_block();
      set_config(21'h1FFFFF, pnr_pkg::WIDTH_MODE_8, 1'b0);
      push_frame(16'h0001, 16'h0000, 1'b1);
      push_frame(16'h00FE, 16'h0000, 1'b0);
      settle_block();
      set_config(21'd1024, pnr_pkg::WIDTH_MODE_16, 1'b1);
      push_frame(16'hA5A5, 16'h5A5A, 1'b1);
      push_frame(16'h0F0F, 16'hF0F0, 1'b0);
      settle_block();

      // random streams, one setting and one idling pattern per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       step = STEP_ONE;
            1:       step = 21'd1024;
            2:       step = 21'd1048576;
            3:       step = pnr_pkg::STEP_W'($urandom_range(1048576, 1024));
            4:       step = pnr_pkg::STEP_W'($urandom_range(65535, 4096));
            5:       step = pnr_pkg::STEP_W'($urandom_range(262144, 65537));
            6:       step = pnr_pkg::STEP_W'($urandom_range(21'h1FFFFF, 0));
            default: step = pnr_pkg::STEP_W'($urandom_range(131072, 1024));
         endcase
         set_config(step, logic'((phase >> 1) & 1) ^ logic'(phase & 1),
                    logic'(((phase >> 2) & 1) == 0 || phase == 7));
         idle_mode = idle_mode_type'(phase % 4);
         // first phase: hold the output off while words are still offered
         if (phase == 0) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            push_frame(pick_sample(), pick_sample(), ($urandom_range(15) == 0) || n == 0);
         end
         settle_block();
      end

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/pnr_pkg.sv
hdl/pnr_ifs.sv
hdl/pnr_ctrl.sv
hdl/pnr_datapath.sv
hdl/pcm_nearest_resampler.sv
tb/pcm_nearest_resampler_checker.sv
tb/pcm_nearest_resampler_test.sv
